>>> hdl/pds_pkg.sv
// Shared types and region codes for the point-to-segment distance pipeline.
// No dependencies.
package pds_pkg;

    localparam logic [1:0] REG_INTERIOR = 2'd0;
    localparam logic [1:0] REG_START    = 2'd1;
    localparam logic [1:0] REG_END      = 2'd2;
    localparam logic [1:0] REG_DEGEN    = 2'd3;

    localparam int DIV_STAGES  = 32;
    localparam int SQRT_STAGES = 34;

    typedef logic [2:0][31:0] t_vec32;
    typedef logic [2:0][32:0] t_vec33;

    typedef struct packed {
        logic [1:0]  region;
        t_vec33      sel;
        t_vec33      vec;
        logic [68:0] rem;
        logic [67:0] c2;
        logic [31:0] quo;
    } t_div_item;

    typedef struct packed {
        logic [1:0]  region;
        logic [67:0] num;
        logic [35:0] rem;
        logic [33:0] root;
    } t_sq_item;

endpackage

>>> hdl/pds_front.sv
// Front stages: differences, exact dot products, region selection.
// Depends on pds_pkg.
module pds_front import pds_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_en,
    input  logic      i_valid,
    input  t_vec32    i_pt,
    input  t_vec32    i_st,
    input  t_vec32    i_ed,
    output logic      o_valid,
    output t_div_item o_item
);

    t_vec33 r1_v, r1_w, r1_u, n1_v, n1_w, n1_u;
    logic   r1_valid;

    t_vec33 r2_v, r2_w, r2_u;
    logic signed [65:0] r2_wv [3];
    logic signed [65:0] r2_vv [3];
    logic   r2_degen, r2_valid;

    t_vec33 r3_v, r3_w, r3_u;
    logic signed [67:0] r3_c1, r3_c2;
    logic   r3_degen, r3_valid;

    t_div_item n4_item, r4_item;
    logic      r4_valid;
    logic      c1_pos, c1_ge;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n1_v[i] = {i_ed[i][31], i_ed[i]} - {i_st[i][31], i_st[i]};
            n1_w[i] = {i_pt[i][31], i_pt[i]} - {i_st[i][31], i_st[i]};
            n1_u[i] = {i_pt[i][31], i_pt[i]} - {i_ed[i][31], i_ed[i]};
        end
    end

    always_comb begin
        c1_pos = !r3_c1[67] && (r3_c1 != 68'sd0);
        c1_ge  = r3_c1 >= r3_c2;
        if (r3_degen) begin
            n4_item.region = REG_DEGEN;
        end else if (!c1_pos) begin
            n4_item.region = REG_START;
        end else if (c1_ge) begin
            n4_item.region = REG_END;
        end else begin
            n4_item.region = REG_INTERIOR;
        end
        n4_item.sel = (n4_item.region == REG_END) ? r3_u : r3_w;
        n4_item.vec = r3_v;
        n4_item.rem = (n4_item.region == REG_INTERIOR) ? {1'b0, r3_c1} : 69'd0;
        n4_item.c2  = r3_c2;
        n4_item.quo = 32'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_v <= n1_v;
            r1_w <= n1_w;
            r1_u <= n1_u;
            r2_v <= r1_v;
            r2_w <= r1_w;
            r2_u <= r1_u;
            r2_degen <= (r1_v == '0);
            for (int i = 0; i < 3; i++) begin
                r2_wv[i] <= $signed(r1_w[i]) * $signed(r1_v[i]);
                r2_vv[i] <= $signed(r1_v[i]) * $signed(r1_v[i]);
            end
            r3_v <= r2_v;
            r3_w <= r2_w;
            r3_u <= r2_u;
            r3_degen <= r2_degen;
            r3_c1 <= 68'(r2_wv[0]) + 68'(r2_wv[1]) + 68'(r2_wv[2]);
            r3_c2 <= 68'(r2_vv[0]) + 68'(r2_vv[1]) + 68'(r2_vv[2]);
            r4_item <= n4_item;
        end
    end

    assign o_valid = r4_valid;
    assign o_item  = r4_item;

endmodule

>>> hdl/pds_div.sv
// Restoring divider, one quotient bit per stage: t = floor(c1 * 2^32 / c2).
// Depends on pds_pkg.
module pds_div import pds_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_en,
    input  logic      i_valid,
    input  t_div_item i_item,
    output logic      o_valid,
    output t_div_item o_item
);

    t_div_item r_item  [DIV_STAGES];
    logic      r_valid [DIV_STAGES];

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
        t_div_item   src, n_item;
        logic        src_valid;
        logic [68:0] sh;
        logic        ge;

        if (k == 0) begin : g_first
            assign src       = i_item;
            assign src_valid = i_valid;
        end else begin : g_rest
            assign src       = r_item[k-1];
            assign src_valid = r_valid[k-1];
        end

        always_comb begin
            sh     = {src.rem[67:0], 1'b0};
            ge     = sh >= {1'b0, src.c2};
            n_item = src;
            n_item.rem = ge ? (sh - {1'b0, src.c2}) : sh;
            n_item.quo = {src.quo[30:0], ge};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (i_en) begin
                r_valid[k] <= src_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_item[k] <= n_item;
            end
        end
    end

    assign o_valid = r_valid[DIV_STAGES-1];
    assign o_item  = r_item[DIV_STAGES-1];

endmodule

>>> hdl/pds_resid.sv
// Residual r = w - floor(t*v/2^32) (interior; else w or u) and sum r^2.
// Depends on pds_pkg.
module pds_resid import pds_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  t_div_item   i_item,
    output logic        o_valid,
    output logic [1:0]  o_region,
    output logic [67:0] o_num
);

    logic signed [65:0] ra_prod [3];
    t_vec33             ra_sel;
    logic [1:0]         ra_region;
    logic               ra_valid;

    logic signed [33:0] rb_res [3];
    logic [1:0]         rb_region;
    logic               rb_valid;

    logic signed [67:0] rc_sq [3];
    logic [1:0]         rc_region;
    logic               rc_valid;

    logic [69:0]        rd_sum;
    logic [1:0]         rd_region;
    logic               rd_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            ra_valid <= 1'b0;
            rb_valid <= 1'b0;
            rc_valid <= 1'b0;
            rd_valid <= 1'b0;
        end else if (i_en) begin
            ra_valid <= i_valid;
            rb_valid <= ra_valid;
            rc_valid <= rb_valid;
            rd_valid <= rc_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            ra_sel    <= i_item.sel;
            ra_region <= i_item.region;
            for (int i = 0; i < 3; i++) begin
                ra_prod[i] <= $signed({1'b0, i_item.quo}) * $signed(i_item.vec[i]);
            end
            rb_region <= ra_region;
            for (int i = 0; i < 3; i++) begin
                rb_res[i] <= $signed({ra_sel[i][32], ra_sel[i]})
                           - ((ra_region == REG_INTERIOR)
                              ? $signed({ra_prod[i][64], ra_prod[i][64:32]}) : 34'sd0);
            end
            rc_region <= rb_region;
            for (int i = 0; i < 3; i++) begin
                rc_sq[i] <= rb_res[i] * rb_res[i];
            end
            rd_region <= rc_region;
            rd_sum    <= {2'b00, rc_sq[0]} + {2'b00, rc_sq[1]} + {2'b00, rc_sq[2]};
        end
    end

    assign o_valid  = rd_valid;
    assign o_region = rd_region;
    assign o_num    = rd_sum[67:0];

endmodule

>>> hdl/pds_sqrt.sv
// Digit-by-digit integer square root, one result bit per stage.
// Depends on pds_pkg.
module pds_sqrt import pds_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  logic [1:0]  i_region,
    input  logic [67:0] i_num,
    output logic        o_valid,
    output logic [1:0]  o_region,
    output logic [33:0] o_root
);

    t_sq_item r_item  [SQRT_STAGES];
    logic     r_valid [SQRT_STAGES];

    for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
        t_sq_item    src, n_item;
        logic        src_valid;
        logic [37:0] cur, trial;
        logic        ge;

        if (k == 0) begin : g_first
            assign src.region = i_region;
            assign src.num    = i_num;
            assign src.rem    = '0;
            assign src.root   = '0;
            assign src_valid  = i_valid;
        end else begin : g_rest
            assign src       = r_item[k-1];
            assign src_valid = r_valid[k-1];
        end

        always_comb begin
            cur    = {src.rem, src.num[67:66]};
            trial  = {2'b00, src.root, 2'b01};
            ge     = cur >= trial;
            n_item = src;
            n_item.rem  = ge ? 36'(cur - trial) : cur[35:0];
            n_item.root = {src.root[32:0], ge};
            n_item.num  = {src.num[65:0], 2'b00};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (i_en) begin
                r_valid[k] <= src_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_item[k] <= n_item;
            end
        end
    end

    assign o_valid  = r_valid[SQRT_STAGES-1];
    assign o_region = r_item[SQRT_STAGES-1].region;
    assign o_root   = r_item[SQRT_STAGES-1].root;

endmodule

>>> hdl/point_to_segment_distance_unit.sv
// Top level of the 3D point-to-segment distance pipeline.
// Depends on pds_pkg, pds_front, pds_div, pds_resid and pds_sqrt.
//
// Takes one beat per cycle unless frozen and returns one result per beat, in
// order, after 4 front stages, 32 divider stages (one quotient bit each),
// 4 residual stages and 34 square-root stages (one root bit each).
// The whole pipeline advances together; it freezes only while the final
// output register holds a result that is not taken.
module point_to_segment_distance_unit import pds_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [31:0] i_point_x,
    input  logic signed [31:0] i_point_y,
    input  logic signed [31:0] i_point_z,
    input  logic signed [31:0] i_start_x,
    input  logic signed [31:0] i_start_y,
    input  logic signed [31:0] i_start_z,
    input  logic signed [31:0] i_end_x,
    input  logic signed [31:0] i_end_y,
    input  logic signed [31:0] i_end_z,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [33:0]        o_distance,
    output logic [1:0]         o_region
);

    logic        en;
    t_vec32      pt, st, ed;
    logic        front_valid, div_valid, res_valid;
    t_div_item   front_item, div_item;
    logic [1:0]  res_region;
    logic [67:0] res_num;

    assign en      = !o_valid || i_ready;
    assign o_ready = en;

    assign pt = {i_point_z, i_point_y, i_point_x};
    assign st = {i_start_z, i_start_y, i_start_x};
    assign ed = {i_end_z, i_end_y, i_end_x};

    pds_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_pt    (pt),
        .i_st    (st),
        .i_ed    (ed),
        .o_valid (front_valid),
        .o_item  (front_item)
    );

    pds_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (front_valid),
        .i_item  (front_item),
        .o_valid (div_valid),
        .o_item  (div_item)
    );

    pds_resid u_resid (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (div_valid),
        .i_item   (div_item),
        .o_valid  (res_valid),
        .o_region (res_region),
        .o_num    (res_num)
    );

    pds_sqrt u_sqrt (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (res_valid),
        .i_region (res_region),
        .i_num    (res_num),
        .o_valid  (o_valid),
        .o_region (o_region),
        .o_root   (o_distance)
    );

`ifndef SYNTHESIS
    a_ready_follows_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready == (!o_valid || i_ready))
        else $error("input ready does not track output stall");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    a_stall_freezes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> ($stable(o_distance) && $stable(o_region)
                                   && $stable(res_valid)))
        else $error("pipeline moved while stalled");
`endif

endmodule

>>> tb/point_to_segment_distance_unit_tb.sv
// Self-checking bench for point_to_segment_distance_unit: streams segment queries,
// predicts distance and region in fixed point, compares each output beat in order.
// Depends on pds_pkg and the distance unit RTL.
module point_to_segment_distance_unit_tb;
    import pds_pkg::*;

    typedef struct {
        logic signed [31:0] c [9];
    } t_query;

    typedef struct {
        logic [33:0] distance;
        logic [1:0]  region;
    } t_answer;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_ready = 1'b0;
    logic signed [31:0] crd [9];
    logic o_ready, o_valid;
    logic [33:0] o_distance;
    logic [1:0]  o_region;

    t_query  pending_q [$];
    t_answer answer_q [$];
    int      n_errors = 0;
    int      hold_off = 0;
    int      burst_left = 0;
    int      gap_left = 0;
    bit      feed_done = 1'b0;
    bit      drain_pause = 1'b0;
    bit      in_acc = 1'b0;

    point_to_segment_distance_unit i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_point_x(crd[0]), .i_point_y(crd[1]), .i_point_z(crd[2]),
        .i_start_x(crd[3]), .i_start_y(crd[4]), .i_start_z(crd[5]),
        .i_end_x(crd[6]), .i_end_y(crd[7]), .i_end_z(crd[8]),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_distance(o_distance), .o_region(o_region)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        for (int k = 0; k < 9; k++) crd[k] = '0;
    end

    function automatic logic [33:0] sqrt_floor(input logic [69:0] n);
        logic [33:0] root;
        logic [33:0] cand;
        root = '0;
        for (int b = 33; b >= 0; b--) begin
            cand = root | (34'd1 << b);
            if ({36'd0, cand} * {36'd0, cand} <= n) root = cand;
        end
        return root;
    endfunction

    function automatic logic [69:0] norm_sq(input logic signed [33:0] a [3]);
        logic signed [69:0] acc;
        acc = '0;
        for (int k = 0; k < 3; k++) acc += 70'(a[k]) * 70'(a[k]);
        return acc;
    endfunction

    function automatic t_answer segment_distance(input t_query q);
        logic signed [33:0] v [3];
        logic signed [33:0] w [3];
        logic signed [33:0] u [3];
        logic signed [33:0] r [3];
        logic signed [71:0] c1, c2;
        logic [103:0] ratio;
        logic signed [71:0] prod;
        t_answer ans;
        c1 = '0;
        c2 = '0;
        for (int k = 0; k < 3; k++) begin
            v[k] = 34'(q.c[6+k]) - 34'(q.c[3+k]);
            w[k] = 34'(q.c[k]) - 34'(q.c[3+k]);
            u[k] = 34'(q.c[k]) - 34'(q.c[6+k]);
            c1 += 72'(w[k]) * 72'(v[k]);
            c2 += 72'(v[k]) * 72'(v[k]);
        end
        if (v[0] == 0 && v[1] == 0 && v[2] == 0) begin
            ans.region = REG_DEGEN;
            ans.distance = sqrt_floor(norm_sq(w));
        end else if (c1 <= 0) begin
            ans.region = REG_START;
            ans.distance = sqrt_floor(norm_sq(w));
        end else if (c1 >= c2) begin
            ans.region = REG_END;
            ans.distance = sqrt_floor(norm_sq(u));
        end else begin
            ratio = ({32'd0, c1} << 32) / {32'd0, c2};
            for (int k = 0; k < 3; k++) begin
                prod = $signed({40'd0, ratio[31:0]}) * 72'(v[k]);
                r[k] = w[k] - 34'(prod >>> 32);
            end
            ans.region = REG_INTERIOR;
            ans.distance = sqrt_floor(norm_sq(r));
        end
        return ans;
    endfunction

    task automatic report_mismatch(input string what, input logic [33:0] got,
                                   input logic [33:0] want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        n_errors++;
    endtask

    function automatic logic [31:0] rand_coord(input int style);
        case (style)
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 2000)) - 1000) <<< 16;
            2: return 32'($signed($urandom_range(0, 200000)) - 100000);
            default: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
        endcase
    endfunction

    task automatic push_query(input t_query q);
        pending_q.push_back(q);
    endtask

    initial begin
        t_query q;
        int style;
        // extremes, degenerate, each region by construction
        foreach (q.c[k]) q.c[k] = 32'h8000_0000;
        push_query(q);
        foreach (q.c[k]) q.c[k] = 32'h7fff_ffff;
        push_query(q);
        foreach (q.c[k]) q.c[k] = (k < 3) ? 32'h7fff_ffff : 32'h8000_0000;
        push_query(q);
        foreach (q.c[k]) q.c[k] = (k < 3) ? 32'h8000_0000 : 32'h7fff_ffff;
        push_query(q);
        foreach (q.c[k]) q.c[k] = (k < 6) ? 32'h8000_0000 : 32'h7fff_ffff;
        push_query(q);
        foreach (q.c[k]) q.c[k] = (k < 3) ? 32'h7fff_ffff :
                                  (k < 6) ? 32'h8000_0000 : 32'h7fff_fffe;
        push_query(q);
        foreach (q.c[k]) q.c[k] = (k % 3 == 0) ? 32'h0 : 32'h0001_0000;
        q.c[0] = 32'h0005_0000; q.c[6] = 32'h000a_0000;
        push_query(q);
        q.c[0] = 32'hfffb_0000;
        push_query(q);
        q.c[0] = 32'h000f_0000;
        push_query(q);
        q.c[0] = 32'h0;
        push_query(q);
        q.c[0] = 32'h000a_0000;
        push_query(q);
        foreach (q.c[k]) q.c[k] = '0;
        push_query(q);
        foreach (q.c[k]) q.c[k] = (k < 3) ? $urandom : 32'h1234_5678;
        push_query(q);
        foreach (q.c[k]) q.c[k] = 32'hffff_ffff;
        q.c[6] = 32'h0;
        push_query(q);
        for (int n = 0; n < 1040; n++) begin
            style = $urandom_range(0, 9);
            foreach (q.c[k]) q.c[k] = rand_coord(style < 4 ? 0 : style < 7 ? 1 :
                                                 style < 9 ? 2 : $urandom_range(0, 3));
            if ($urandom_range(0, 19) == 0)
                for (int k = 0; k < 3; k++) q.c[6+k] = q.c[3+k];
            push_query(q);
        end
        feed_done = 1'b1;
    end

    // input beat taken at this rising edge
    always @(posedge i_clk) begin
        in_acc <= i_rst_n && i_valid && o_ready;
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (i_valid && !in_acc) begin
        end else begin
            if (i_valid) begin
                answer_q.push_back(segment_distance(pending_q.pop_front()));
                if (pending_q.size() == 700) drain_pause = 1'b1;
            end
            if (drain_pause && answer_q.size() == 0) drain_pause = 1'b0;
            if (gap_left > 0) gap_left--;
            if (burst_left == 0 && gap_left == 0) begin
                burst_left = $urandom_range(1, 40);
                gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
            end
            if (pending_q.size() != 0 && gap_left == 0 && !drain_pause) begin
                for (int k = 0; k < 9; k++) crd[k] <= pending_q[0].c[k];
                i_valid <= 1'b1;
                burst_left--;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (pending_q.size() == 900 && hold_off == 0 && i_valid) begin
            hold_off <= 300;
            i_ready <= 1'b0;
        end else if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            i_ready <= (hold_off == 1);
        end else begin
            i_ready <= ($urandom_range(0, 9) < (pending_q.size() % 200 < 60 ? 10 : 7));
        end
    end

    always @(posedge i_clk) begin
        t_answer want;
        if (i_rst_n && o_valid && i_ready) begin
            if (answer_q.size() == 0) begin
                report_mismatch("unexpected beat", o_distance, 0);
            end else begin
                want = answer_q.pop_front();
                if (o_distance !== want.distance)
                    report_mismatch("distance", o_distance, want.distance);
                if (o_region !== want.region)
                    report_mismatch("region", 34'(o_region), 34'(want.region));
            end
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        wait (feed_done && pending_q.size() == 0 && !i_valid);
        wait (answer_q.size() == 0);
        repeat (100) @(posedge i_clk);
        if (n_errors == 0 && answer_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #600000;
        $display("FAILURE");
        $finish;
    end
endmodule
